// ===== rtl/core/newton_square_root_unit_defines.svh =====
// Assertion macros for the Newton square root unit.
// No dependencies; included by the files that carry assertions.
`ifndef NEWTON_SQUARE_ROOT_UNIT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NSR_ASSERT(lbl, prop, msg)
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/nsr_pkg.sv =====
// Shared widths, types and state codes of the Newton square root unit.
// No dependencies.
package nsr_pkg;
  localparam int VALUE_BITS = 31;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = 16;
  localparam int ITER_W     = 6;
  localparam int ROOT_OUT_W = 32;
  // estimate never exceeds 2^47 for a 31-bit value (Newton stays above isqrt)
  localparam int R_W        = 48;
  localparam int NUM_W      = VALUE_BITS + 2 * FRAC_BITS;
  localparam int SQ_W       = 2 * R_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } nsr_unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_UPDATE
  } nsr_state_t;
endpackage

// ===== rtl/core/nsr_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nsr_pkg.
module nsr_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsr_pkg::NUM_W-1:0]  num,
  input  logic [nsr_pkg::R_W-1:0]    den,
  output logic [nsr_pkg::R_W-1:0]    quot,
  output nsr_pkg::nsr_unit_stat_t    stat
);
  import nsr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic [R_W:0]       rem_r, rem_nxt, trial;
  logic [NUM_W-1:0]   num_r;
  logic [R_W-1:0]     den_r, quot_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r, ge;

  assign trial   = {rem_r[R_W-1:0], num_r[NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? trial - {1'b0, den_r} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      num_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      quot_r <= {quot_r[R_W-2:0], ge};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/core/nsr_squarer.sv =====
// Bit-serial squarer: MSB-first shift-and-add, one multiplier bit per cycle.
// Depends on nsr_pkg.
module nsr_squarer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [nsr_pkg::R_W-1:0]  a,
  output logic [nsr_pkg::SQ_W-1:0] prod,
  output nsr_pkg::nsr_unit_stat_t  stat
);
  import nsr_pkg::*;

  localparam int CNT_W = $clog2(R_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(R_W - 1);

  logic [R_W-1:0]   a_r, mul_r;
  logic [SQ_W-1:0]  acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      mul_r <= a;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[SQ_W-2:0], 1'b0} + (mul_r[R_W-1] ? {{R_W{1'b0}}, a_r} : '0);
      mul_r <= {mul_r[R_W-2:0], 1'b0};
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/core/newton_square_root_unit.sv =====
// Newton square root unit, top level: sequencer, config registers, result.
// Depends on nsr_pkg, nsr_squarer, nsr_divider, newton_square_root_unit_defines.svh.
//
// Usage:
//  - Input: raise start with in_value; the beat is taken when start is high and
//    busy low. busy stays high until the result beat has been issued.
//  - Result: out_valid is high for exactly one cycle with out_root (Q16.16,
//    clamped to all ones), out_steps_taken and out_converged. The receiver
//    cannot stall; the beat is gone after that cycle.
//  - Config: cfg_we/cfg_index/cfg_wdata write tolerance (index 0) or the step
//    cap (index 1); other indexes are ignored. Write while idle.
//  - Sequence: each tolerance check squares the estimate bit-serially, each
//    Newton step divides bit-serially and then updates the estimate. The step
//    cap (40 after reset) bounds the number of steps per item, and so how long
//    an item takes; the two serial units set the pace.
//  - Reset: synchronous, active low; tolerance returns to 66, cap to 40, the
//    sequencer to idle. No state carries between items.
module newton_square_root_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [nsr_pkg::VALUE_BITS-1:0]      in_value,
  output logic                                out_valid,
  output logic [nsr_pkg::ROOT_OUT_W-1:0]      out_root,
  output logic [nsr_pkg::ITER_W-1:0]          out_steps_taken,
  output logic                                out_converged,
  input  logic                                cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nsr_pkg::TOL_W-1:0]           cfg_wdata
);
  import nsr_pkg::*;
`include "newton_square_root_unit_defines.svh"

  localparam int DIFF_W = SQ_W - FRAC_BITS;
  localparam logic [R_W-1:0] ONE_Q = R_W'(1) << FRAC_BITS;

  nsr_state_t state_r, state_nxt;

  logic [TOL_W-1:0]      tol_r;
  logic [ITER_W-1:0]     max_it_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [R_W-1:0]        r_r, r_nxt;
  logic [ITER_W-1:0]     steps_r, steps_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ROOT_OUT_W-1:0] out_root_r, out_root_nxt;
  logic [ITER_W-1:0]     out_steps_r, out_steps_nxt;
  logic                  out_conv_r, out_conv_nxt;

  logic                  sq_start, div_start;
  logic [SQ_W-1:0]       sq_prod;
  logic [R_W-1:0]        quot;
  nsr_unit_stat_t        sq_stat, div_stat;

  logic [DIFF_W-1:0]     sq_scaled, target, diff;
  logic                  close;
  logic [R_W:0]          sum;
  logic [ROOT_OUT_W-1:0] root_clamped;

  // config registers: keep only each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_W'(66);
      max_it_r <= ITER_W'(40);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tol_r    <= cfg_wdata;
        CFG_MAX_ITER:  max_it_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  nsr_squarer u_sq (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .a    (r_r),
    .prod (sq_prod),
    .stat (sq_stat)
  );

  // numerator is value << 2*FRAC_BITS
  nsr_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  ({val_r, {(2 * FRAC_BITS){1'b0}}}),
    .den  (r_r),
    .quot (quot),
    .stat (div_stat)
  );

  // |floor(r*r >> F) - (v << F)| < tolerance
  assign sq_scaled = sq_prod[SQ_W-1:FRAC_BITS];
  assign target    = {{(DIFF_W - VALUE_BITS - FRAC_BITS){1'b0}}, val_r, {FRAC_BITS{1'b0}}};
  assign diff      = (sq_scaled >= target) ? sq_scaled - target : target - sq_scaled;
  assign close     = diff < {{(DIFF_W - TOL_W){1'b0}}, tol_r};

  assign sum          = {1'b0, quot} + {1'b0, r_r};
  assign root_clamped = (|r_r[R_W-1:ROOT_OUT_W]) ? '1 : r_r[ROOT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == ST_IDLE) val_r <= in_value;
    r_r         <= r_nxt;
    steps_r     <= steps_nxt;
    out_root_r  <= out_root_nxt;
    out_steps_r <= out_steps_nxt;
    out_conv_r  <= out_conv_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_root_nxt  = out_root_r;
    out_steps_nxt = out_steps_r;
    out_conv_nxt  = out_conv_r;
    sq_start      = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          r_nxt     = ONE_Q;
          steps_nxt = '0;
          state_nxt = ST_SQ_START;
        end
      end
      ST_SQ_START: begin
        sq_start  = 1'b1;
        state_nxt = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (sq_stat.done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // stop on tolerance met or cap reached; else take a step
        if (close || steps_r >= max_it_r) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = root_clamped;
          out_steps_nxt = steps_r;
          out_conv_nxt  = close;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // r = (q + r) / 2, held at one LSB
        r_nxt     = (sum[R_W:1] == '0) ? R_W'(1) : sum[R_W:1];
        steps_nxt = steps_r + 1'b1;
        state_nxt = ST_SQ_START;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_root        = out_root_r;
  assign out_steps_taken = out_steps_r;
  assign out_converged   = out_conv_r;

  `NSR_ASSERT(a_steps_cap, out_valid |-> out_steps_taken <= max_it_r, "steps beyond cap")
  `NSR_ASSERT(a_noconv_at_cap,
              (out_valid && !out_converged) |-> out_steps_taken == max_it_r,
              "gave up before cap")
  `NSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat not busy")
  `NSR_ASSERT(a_units_excl, !(sq_stat.busy && div_stat.busy), "squarer and divider both running")
  `NSR_ASSERT_NEXT(a_single_beat, out_valid, !out_valid, "result beat repeated")
endmodule

// ===== verif/newton_square_root_unit_checker.sv =====
// Watches the command, result and config channels of newton_square_root_unit,
// predicts every result and compares it. Depends on nsr_pkg.
module newton_square_root_unit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [nsr_pkg::VALUE_BITS-1:0] in_value,
  input  logic                           out_valid,
  input  logic [nsr_pkg::ROOT_OUT_W-1:0] out_root,
  input  logic [nsr_pkg::ITER_W-1:0]     out_steps_taken,
  input  logic                           out_converged,
  input  logic                           cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsr_pkg::TOL_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             roots_pending,
  output int                             roots_checked,
  output int                             roots_converged
);
  timeunit 1ns;
  timeprecision 1ps;
  import nsr_pkg::*;

  typedef struct packed {
    logic [ROOT_OUT_W-1:0] root;
    logic [ITER_W-1:0]     steps;
    logic                  conv;
  } sqrt_result_t;

  logic [TOL_W-1:0]  tol_q;
  logic [ITER_W-1:0] cap_q;
  sqrt_result_t      expected_roots[$];

  // |r*r - v| < tol in Q.16
  function automatic logic within_tol(logic [63:0] r, logic [63:0] v, logic [TOL_W-1:0] tol);
    logic [127:0] prod;
    logic [63:0]  sq, target, diff;
    prod = {64'd0, r} * {64'd0, r};
    if (prod[127:64+FRAC_BITS] != 0) return 1'b0;
    sq = prod[64+FRAC_BITS-1:FRAC_BITS];
    target = v << FRAC_BITS;
    diff = (sq >= target) ? sq - target : target - sq;
    return diff < {48'd0, tol};
  endfunction

  function automatic sqrt_result_t newton_root(logic [VALUE_BITS-1:0] value);
    logic [63:0]  v, r, q, num;
    int unsigned  n;
    sqrt_result_t res;
    v = {33'd0, value};
    r = 64'd1 << FRAC_BITS;
    n = 0;
    res.conv = 1'b0;
    num = v << (2 * FRAC_BITS);
    forever begin
      if (within_tol(r, v, tol_q)) begin
        res.conv = 1'b1;
        break;
      end
      if (n >= cap_q) break;
      q = num / r;
      if (q >= (64'd1 << 62)) q = (64'd1 << 62) - 1;  // quotient saturates
      r = (q + r) >> 1;
      if (r == 0) r = 64'd1;  // hold at one LSB
      n++;
    end
    res.root = (r > 64'hFFFF_FFFF) ? '1 : r[31:0];
    res.steps = n[ITER_W-1:0];
    return res;
  endfunction

  assign roots_pending = expected_roots.size();

  always @(posedge clk) begin
    sqrt_result_t want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      tol_q <= 16'd66;
      cap_q <= 6'd40;
      fail_count <= 0;
      roots_checked <= 0;
      roots_converged <= 0;
      expected_roots.delete();
    end else begin
      if (start && !busy) expected_roots.push_back(newton_root(in_value));
      if (out_valid) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with nothing expected: root=%h", out_root);
          errs++;
        end else begin
          want = expected_roots.pop_front();
          roots_checked <= roots_checked + 1;
          if (want.conv) roots_converged <= roots_converged + 1;
          if (out_root !== want.root) begin
            $error("root: expected %h, got %h", want.root, out_root);
            errs++;
          end
          if (out_steps_taken !== want.steps) begin
            $error("steps_taken: expected %0d, got %0d", want.steps, out_steps_taken);
            errs++;
          end
          if (out_converged !== want.conv) begin
            $error("converged: expected %b, got %b", want.conv, out_converged);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (cfg_we) begin
        if (cfg_index == CFG_TOLERANCE) tol_q <= cfg_wdata;
        else if (cfg_index == CFG_MAX_ITER) cap_q <= cfg_wdata[ITER_W-1:0];
      end
    end
  end
endmodule

// ===== verif/newton_square_root_unit_tb.sv =====
// Top of the newton_square_root_unit testbench: clock, reset, stimulus, verdict.
// Depends on nsr_pkg, newton_square_root_unit and newton_square_root_unit_checker.
module newton_square_root_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsr_pkg::*;

  // limit covers 588 items at the longest step cap plus gaps, several times over
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     RAND_PER_PHASE = 95;

  logic                  clk, rst_n, start, busy;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid, out_converged;
  logic [ROOT_OUT_W-1:0] out_root;
  logic [ITER_W-1:0]     out_steps_taken;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TOL_W-1:0]      cfg_wdata;
  int                    fail_count, roots_pending, roots_checked, roots_converged;
  longint                cycle_count;
  bit                    no_gaps;

  newton_square_root_unit dut (.*);

  newton_square_root_unit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One command beat: optional idle gap, then start held until the unit takes it.
  task automatic send_value(logic [VALUE_BITS-1:0] v);
    int gap;
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 36) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Config writes only once the unit is drained and idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (roots_pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Squares and near-squares (30%), small values (25%), the rest full range.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned k, s;
    k = $urandom_range(99);
    if (k < 30) begin
      s = $urandom_range(46340);
      return VALUE_BITS'(s * s + $urandom_range(2) - 1);
    end
    if (k < 55) return VALUE_BITS'($urandom_range(300));
    return VALUE_BITS'($urandom);
  endfunction

  task automatic random_burst();
    repeat (RAND_PER_PHASE) send_value(pick_value());
    drain();
  endtask

  initial begin
    logic [VALUE_BITS-1:0] directed[$];
    cycle_count = 0;
    no_gaps = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TOLERANCE;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: value extremes, squares, alternating bit patterns
    directed = '{0, 1, 2, 3, 4, 255, 65536, 1 << 30, 31'h7FFF_FFFF,
                 31'h5555_5555, 31'h2AAA_AAAA, 46340 * 46340, 12345};
    foreach (directed[i]) send_value(directed[i]);
    drain();
    random_burst();

    // zero tolerance: never converges, runs the cap; cap data beyond 6 bits
    write_reg(CFG_TOLERANCE, 16'd0);
    write_reg(CFG_MAX_ITER, 16'hFFC5);
    send_value(31'h7FFF_FFFF);
    send_value(0);
    random_burst();

    // tightest tolerance that can still converge, longest cap, no idle gaps at all
    write_reg(CFG_TOLERANCE, 16'd1);
    write_reg(CFG_MAX_ITER, 16'd63);
    no_gaps = 1;
    random_burst();
    no_gaps = 0;

    // loosest tolerance, zero cap: only 1.0 ever reported
    write_reg(CFG_TOLERANCE, 16'hFFFF);
    write_reg(CFG_MAX_ITER, 16'd0);
    send_value(1);
    random_burst();

    // single step: huge estimates clamp to all ones; writes to unused indexes
    write_reg(CFG_TOLERANCE, 16'd100);
    write_reg(CFG_MAX_ITER, 16'd1);
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h0000);
    send_value(31'h7FFF_FFFF);
    send_value(0);
    random_burst();

    write_reg(CFG_TOLERANCE, 16'd66);
    write_reg(CFG_MAX_ITER, 16'd40);
    random_burst();

    $display("Checked %0d roots (%0d converged) over six register settings,",
             roots_checked, roots_converged);
    $display("including zero tolerance, zero and maximum step caps.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
